>>> rtl/core/cbr_pkg.sv
// ----------------------------------------------------------------------------
// cbr_pkg
// Shared types and constants of the chunked blob receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cbr_pkg;

  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_END   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_BLOB_OK   = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_OUT_ORDER = 3'd3,
    ST_CHUNK_OVF = 3'd4,
    ST_LEN_BAD   = 3'd5,
    ST_CRC_BAD   = 3'd6
  } status_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] declared_len;
    logic [31:0] expected_crc;
    logic [15:0] chunk_index;
    logic [15:0] chunk_len;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic        store_enable;
    logic [15:0] store_address;
    logic [7:0]  store_byte;
    status_e     status;
    logic [31:0] computed_crc;
    logic [15:0] blob_length;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/cbr_if.sv
// ----------------------------------------------------------------------------
// cbr_if
// Valid/ready channels of the blob receiver: request in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] declared_len;
  logic [31:0] expected_crc;
  logic [15:0] chunk_index;
  logic [15:0] chunk_len;
  logic [7:0]  data_byte;

  modport source (
    output valid, func, declared_len, expected_crc, chunk_index, chunk_len, data_byte,
    input  ready
  );
  modport sink (
    input  valid, func, declared_len, expected_crc, chunk_index, chunk_len, data_byte,
    output ready
  );
endinterface

interface cbr_out_if;
  logic        valid;
  logic        ready;
  logic        store_enable;
  logic [15:0] store_address;
  logic [7:0]  store_byte;
  logic [2:0]  status;
  logic [31:0] computed_crc;
  logic [15:0] blob_length;

  modport source (
    output valid, store_enable, store_address, store_byte, status, computed_crc,
           blob_length,
    input  ready
  );
  modport sink (
    input  valid, store_enable, store_address, store_byte, status, computed_crc,
           blob_length,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/cbr_crc32.sv
// ----------------------------------------------------------------------------
// cbr_crc32
// One byte step of the reflected CRC-32, unrolled over the eight bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_crc32 (
  input  logic [31:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [31:0] crc_o
);
  import cbr_pkg::*;

  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'd0, data_i};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

>>> rtl/core/cbr_blob_ctrl.sv
// ----------------------------------------------------------------------------
// cbr_blob_ctrl
// Blob state, chunk checks and result forming for one request per step.
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_blob_ctrl #(
  parameter int unsigned BUFFER_CAPACITY = 40960
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  cbr_pkg::in_item_t   item_i,
  output cbr_pkg::out_item_t  result_o
);
  import cbr_pkg::*;

  localparam logic [31:0] CapW = 32'(BUFFER_CAPACITY);

  logic        active_q, active_d;
  logic        too_large_q, too_large_d;
  logic [31:0] declared_total_q, declared_total_d;
  logic [15:0] bytes_received_q, bytes_received_d;
  logic [31:0] crc_expected_q, crc_expected_d;
  logic [15:0] next_chunk_q, next_chunk_d;
  logic [15:0] chunk_left_q, chunk_left_d;
  logic [31:0] running_crc_q, running_crc_d;

  logic [31:0] crc_next;
  logic [31:0] final_crc;
  logic [31:0] chunk_end;
  logic        first_byte;
  logic        bad_index;
  logic        no_fit;

  cbr_crc32 u_crc (
    .crc_i  (running_crc_q),
    .data_i (item_i.data_byte),
    .crc_o  (crc_next)
  );

  assign final_crc  = running_crc_q ^ CRC_ALL_ONES;
  assign chunk_end  = {16'd0, bytes_received_q} + {16'd0, item_i.chunk_len};
  assign first_byte = (chunk_left_q == 16'd0);
  assign bad_index  = (item_i.chunk_index != next_chunk_q);
  assign no_fit     = (chunk_end > CapW) || (chunk_end > declared_total_q);

  always_comb begin
    logic take;
    active_d         = active_q;
    too_large_d      = too_large_q;
    declared_total_d = declared_total_q;
    bytes_received_d = bytes_received_q;
    crc_expected_d   = crc_expected_q;
    next_chunk_d     = next_chunk_q;
    chunk_left_d     = chunk_left_q;
    running_crc_d    = running_crc_q;
    result_o         = '0;
    take             = 1'b0;

    case (item_i.func)
      FUNC_BEGIN: begin
        declared_total_d = item_i.declared_len;
        bytes_received_d = '0;
        crc_expected_d   = item_i.expected_crc;
        next_chunk_d     = '0;
        chunk_left_d     = '0;
        running_crc_d    = CRC_ALL_ONES;
        active_d         = 1'b1;
        too_large_d      = (item_i.declared_len > CapW);
        result_o.status  = too_large_d ? ST_TOO_LARGE : ST_NONE;
      end
      FUNC_BYTE: begin
        if (active_q && !too_large_q) begin
          take = 1'b1;
          if (first_byte) begin
            if (bad_index) begin
              active_d        = 1'b0;
              result_o.status = ST_OUT_ORDER;
              take            = 1'b0;
            end else if (no_fit) begin
              active_d        = 1'b0;
              result_o.status = ST_CHUNK_OVF;
              take            = 1'b0;
            end else begin
              next_chunk_d = next_chunk_q + 16'd1;
              chunk_left_d = item_i.chunk_len;
              take         = (item_i.chunk_len != 16'd0);
            end
          end
          if (take) begin
            result_o.store_enable  = 1'b1;
            result_o.store_address = bytes_received_q;
            result_o.store_byte    = item_i.data_byte;
            running_crc_d          = crc_next;
            bytes_received_d       = bytes_received_q + 16'd1;
            chunk_left_d           = chunk_left_d - 16'd1;
          end
        end
      end
      FUNC_END: begin
        if (active_q) begin
          active_d     = 1'b0;
          chunk_left_d = '0;
          if (too_large_q) begin
            result_o.status = ST_TOO_LARGE;
          end else begin
            result_o.computed_crc = final_crc;
            result_o.blob_length  = bytes_received_q;
            if ({16'd0, bytes_received_q} != declared_total_q) begin
              result_o.status = ST_LEN_BAD;
            end else if (final_crc != crc_expected_q) begin
              result_o.status = ST_CRC_BAD;
            end else begin
              result_o.status = ST_BLOB_OK;
            end
          end
        end
      end
      default: begin
        // unused code: no state change, empty result
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q         <= 1'b0;
      too_large_q      <= 1'b0;
      declared_total_q <= '0;
      bytes_received_q <= '0;
      crc_expected_q   <= '0;
      next_chunk_q     <= '0;
      chunk_left_q     <= '0;
      running_crc_q    <= CRC_ALL_ONES;
    end else if (step_i) begin
      active_q         <= active_d;
      too_large_q      <= too_large_d;
      declared_total_q <= declared_total_d;
      bytes_received_q <= bytes_received_d;
      crc_expected_q   <= crc_expected_d;
      next_chunk_q     <= next_chunk_d;
      chunk_left_q     <= chunk_left_d;
      running_crc_q    <= running_crc_d;
    end
  end

  // accepted bytes never run past the buffer
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {16'd0, bytes_received_q} <= CapW)
    else $error("byte count beyond buffer capacity");

  // an open chunk implies an open, admissible blob
  a_chunk_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chunk_left_q != 16'd0) |-> (active_q && !too_large_q))
    else $error("chunk open outside an active blob");

endmodule

`default_nettype wire

>>> rtl/core/chunked_blob_receiver_crc32_core.sv
// ----------------------------------------------------------------------------
// chunked_blob_receiver_crc32_core
// Chunked blob reassembly with bound checks and reflected CRC-32.
// ----------------------------------------------------------------------------
// One request in, one result out, at up to one request per clock. A request
// lands in an input register, passes the blob checks and the byte-wide
// CRC-32 step in a single combinational pass, and the result lands in an
// output register, which drives the result valid. Throughput is one request
// per cycle while the result side does not stall, set by the combinational
// CRC byte step and the update of the blob state. The input side keeps
// taking requests while a result waits, until both registers are full.
// Begin restarts the blob; every accepted chunk byte gets a store address
// (its offset in the buffer); end reports length and CRC status.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_blob_receiver_crc32_core #(
  parameter int unsigned BUFFER_CAPACITY = 40960
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbr_in_if.sink    in_i,
  cbr_out_if.source out_o
);
  import cbr_pkg::*;

  // input register
  logic      in_valid_q;
  in_item_t  in_item_q;
  // output register
  logic      out_valid_q;
  out_item_t res_q;
  out_item_t res_d;

  logic      step;

  // the pass fires when the input register holds a request and the output
  // register is free or being drained this cycle
  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q.func         <= func_e'(in_i.func);
      in_item_q.declared_len <= in_i.declared_len;
      in_item_q.expected_crc <= in_i.expected_crc;
      in_item_q.chunk_index  <= in_i.chunk_index;
      in_item_q.chunk_len    <= in_i.chunk_len;
      in_item_q.data_byte    <= in_i.data_byte;
    end
  end

  cbr_blob_ctrl #(
    .BUFFER_CAPACITY (BUFFER_CAPACITY)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.store_enable  = res_q.store_enable;
  assign out_o.store_address = res_q.store_address;
  assign out_o.store_byte    = res_q.store_byte;
  assign out_o.status        = res_q.status;
  assign out_o.computed_crc  = res_q.computed_crc;
  assign out_o.blob_length   = res_q.blob_length;

  // a stored byte never carries a status
  a_store_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.store_enable) |-> (res_q.status == ST_NONE))
    else $error("store result with nonzero status");

  // both registers full and output stalled: no new request taken
  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("request accepted while pipeline full");

  // a request in the input register moves into the output register when the
  // output register is free or being drained
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && (!out_valid_q || out_o.ready)) |=> out_valid_q)
    else $error("request lost between registers");

  // CRC and length are only reported with an end status
  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.blob_length != 16'd0)) |->
      (res_q.status == ST_BLOB_OK || res_q.status == ST_LEN_BAD ||
       res_q.status == ST_CRC_BAD))
    else $error("blob length reported without end status");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chunked blob receiver with CRC-32 check.
// A table of directed requests covers the corner cases, then randomized
// blobs follow: half well-formed, the rest broken on purpose or noise.
// Every accepted request is run through a
// local model of the blob state. Every result is compared field by field
// against the oldest predicted outcome. Both handshake sides idle at random,
// and once the result side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cbr_pkg::*;

  localparam int unsigned BUF_CAP        = 40960;
  localparam logic [1:0]  FUNC_UNUSED    = 2'd3;   // undefined opcode, must be ignored
  localparam int          RANDOM_REQS    = 850;    // effective requests in the random phase
  localparam int          HOLD_CYCLES    = 200;    // long result-side hold-off
  localparam int          HOLD_AFTER     = 300;    // start hold-off after this many requests
  localparam int          WATCHDOG_LIMIT = 2000;   // idle cycles before giving up
  localparam int          DRAIN_CYCLES   = 10;     // margin after the last expected result
  localparam int          MAX_REPORTS    = 10;

  // One directed table row: the request, plus a hand-written outcome where
  // the answer is obvious (typed = 1). Other rows use the predictor.
  typedef struct packed {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } step_row_t;

  logic clk_i;
  logic rst_ni;

  cbr_in_if  in_ch ();
  cbr_out_if out_ch ();

  chunked_blob_receiver_crc32_core #(
    .BUFFER_CAPACITY (BUF_CAP)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // --------------------------------------------------------------------------
  // Blob state of the predictor (mirrors the block's registers)
  // --------------------------------------------------------------------------
  bit          blob_open;
  bit          blob_oversize;
  logic [31:0] decl_len;
  logic [15:0] rx_count;
  logic [31:0] want_crc;
  logic [15:0] chunk_seq;
  logic [15:0] chunk_remaining;
  logic [31:0] crc_acc;
  bit          req_effective;   // last request changed state or produced output

  out_item_t   predicted_outcomes[$];
  step_row_t   directed_rows[$];
  int          mismatch_count;
  int          work_count;      // requests that the block did not just ignore
  bit          sender_calm;     // no input gaps for the current blob
  logic        hold_off;        // result side forced to stall

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Reflected CRC-32, one byte, LSB first.
  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Result of one request; updates the blob state as the block does.
  function automatic out_item_t predict_outcome(input in_item_t req);
    out_item_t   res;
    logic [31:0] chunk_end;
    bit          take;
    res           = '0;
    req_effective = 1'b0;
    case (req.func)
      FUNC_BEGIN: begin
        // begin always restarts, even in the middle of another blob
        decl_len        = req.declared_len;
        rx_count        = '0;
        want_crc        = req.expected_crc;
        chunk_seq       = '0;
        chunk_remaining = '0;
        crc_acc         = CRC_ALL_ONES;
        blob_open       = 1'b1;
        blob_oversize   = req.declared_len > BUF_CAP;
        res.status      = blob_oversize ? ST_TOO_LARGE : ST_NONE;
        req_effective   = 1'b1;
      end
      FUNC_BYTE: begin
        if (blob_open && !blob_oversize) begin
          req_effective = 1'b1;
          take          = 1'b1;
          // chunk header fields only count on the first byte of a chunk
          if (chunk_remaining == 16'd0) begin
            chunk_end = {16'd0, rx_count} + {16'd0, req.chunk_len};
            if (req.chunk_index != chunk_seq) begin
              blob_open  = 1'b0;
              res.status = ST_OUT_ORDER;
              take       = 1'b0;
            end else if (chunk_end > BUF_CAP || chunk_end > decl_len) begin
              blob_open  = 1'b0;
              res.status = ST_CHUNK_OVF;
              take       = 1'b0;
            end else begin
              chunk_seq       = chunk_seq + 16'd1;   // wraps at 16 bits
              chunk_remaining = req.chunk_len;
              if (req.chunk_len == 16'd0) take = 1'b0;  // empty chunk, no store
            end
          end
          if (take) begin
            res.store_enable  = 1'b1;
            res.store_address = rx_count;
            res.store_byte    = req.data_byte;
            crc_acc           = crc32_step(crc_acc, req.data_byte);
            rx_count          = rx_count + 16'd1;
            chunk_remaining   = chunk_remaining - 16'd1;
          end
        end
      end
      FUNC_END: begin
        if (blob_open) begin
          req_effective   = 1'b1;
          blob_open       = 1'b0;
          chunk_remaining = '0;
          if (blob_oversize) begin
            res.status = ST_TOO_LARGE;
          end else begin
            res.computed_crc = crc_acc ^ CRC_ALL_ONES;
            res.blob_length  = rx_count;
            if ({16'd0, rx_count} != decl_len)         res.status = ST_LEN_BAD;
            else if (res.computed_crc != want_crc)     res.status = ST_CRC_BAD;
            else                                       res.status = ST_BLOB_OK;
          end
        end
      end
      default: ;  // unused opcode: no effect
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly zero, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Request with every field random except the opcode.
  function automatic in_item_t random_req(input func_e f);
    in_item_t it;
    it.func         = f;
    it.declared_len = $urandom;
    it.expected_crc = $urandom;
    it.chunk_index  = 16'($urandom);
    it.chunk_len    = 16'($urandom);
    it.data_byte    = 8'($urandom);
    return it;
  endfunction

  // Offer one request, wait for the handshake, then log its predicted outcome.
  task automatic send_req(input in_item_t req, input bit typed, input out_item_t want);
    int        gap;
    out_item_t pred;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= req.func;
    in_ch.declared_len <= req.declared_len;
    in_ch.expected_crc <= req.expected_crc;
    in_ch.chunk_index  <= req.chunk_index;
    in_ch.chunk_len    <= req.chunk_len;
    in_ch.data_byte    <= req.data_byte;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    // predictor always runs so its state tracks the block
    pred = predict_outcome(req);
    predicted_outcomes.push_back(typed ? want : pred);
    if (req_effective) work_count++;
  endtask

  task automatic add_row(input logic [1:0] f, input logic [31:0] tlen, input logic [31:0] ecrc,
                         input logic [15:0] idx, input logic [15:0] clen, input logic [7:0] db,
                         input bit typed, input status_e st, input logic [31:0] crc,
                         input logic [15:0] blen);
    step_row_t row;
    row                   = '0;
    row.req.func          = func_e'(f);
    row.req.declared_len  = tlen;
    row.req.expected_crc  = ecrc;
    row.req.chunk_index   = idx;
    row.req.chunk_len     = clen;
    row.req.data_byte     = db;
    row.typed             = typed;
    row.want.status       = st;
    row.want.computed_crc = crc;
    row.want.blob_length  = blen;
    directed_rows.push_back(row);
  endtask

  // Corner cases. Typed outcomes only where the answer is plain.
  task automatic build_directed();
    // nothing open: byte and end are ignored, so is the unused opcode
    add_row(FUNC_BYTE,   32'd0, 32'd0, 16'd0, 16'd1, 8'hFF, 1, ST_NONE, 32'd0, 16'd0);
    add_row(FUNC_END,    32'd0, 32'd0, 16'd0, 16'd0, 8'h00, 1, ST_NONE, 32'd0, 16'd0);
    add_row(FUNC_UNUSED, '1, '1, '1, '1, '1,                1, ST_NONE, 32'd0, 16'd0);
    // oversize blob: bytes ignored, end reports too large
    add_row(FUNC_BEGIN,  '1, '1, 16'd0, 16'd0, 8'h00,       1, ST_TOO_LARGE, 32'd0, 16'd0);
    add_row(FUNC_BYTE,   32'd0, 32'd0, 16'd0, 16'd1, 8'h5A, 1, ST_NONE, 32'd0, 16'd0);
    add_row(FUNC_END,    32'd0, 32'd0, 16'd0, 16'd0, 8'h00, 1, ST_TOO_LARGE, 32'd0, 16'd0);
    // one past capacity is too large, exactly capacity is fine
    add_row(FUNC_BEGIN,  BUF_CAP + 1, 32'd0, 16'd0, 16'd0, 8'h00, 1, ST_TOO_LARGE, 32'd0, 16'd0);
    add_row(FUNC_BEGIN,  BUF_CAP, 32'd0, 16'd0, 16'd0, 8'h00,     1, ST_NONE, 32'd0, 16'd0);
    // first chunk must be index zero
    add_row(FUNC_BYTE,   32'd0, 32'd0, 16'hFFFF, 16'd1, 8'h00, 1, ST_OUT_ORDER, 32'd0, 16'd0);
    // chunk longer than the declared total
    add_row(FUNC_BEGIN,  32'd2, 32'd0, 16'd0, 16'd0, 8'h00,    1, ST_NONE, 32'd0, 16'd0);
    add_row(FUNC_BYTE,   32'd0, 32'd0, 16'd0, 16'hFFFF, 8'h00, 1, ST_CHUNK_OVF, 32'd0, 16'd0);
    // check string "123456789" split 4 / empty / 5; later bytes carry junk
    // chunk fields that must be ignored
    add_row(FUNC_BEGIN,  32'd9, 32'hCBF4_3926, 16'd0, 16'd0, 8'h00, 1, ST_NONE, 32'd0, 16'd0);
    add_row(FUNC_BYTE,   32'd0, 32'd0, 16'd0, 16'd4, 8'h31, 0, ST_NONE, 32'd0, 16'd0);
    for (int k = 2; k <= 4; k++) begin
      add_row(FUNC_BYTE, '1, '1, 16'hFFFF, 16'hFFFF, 8'h30 + 8'(k), 0, ST_NONE, 32'd0, 16'd0);
    end
    add_row(FUNC_BYTE,   32'd0, 32'd0, 16'd1, 16'd0, 8'hAA, 1, ST_NONE, 32'd0, 16'd0);
    add_row(FUNC_BYTE,   32'd0, 32'd0, 16'd2, 16'd5, 8'h35, 0, ST_NONE, 32'd0, 16'd0);
    for (int k = 6; k <= 9; k++) begin
      add_row(FUNC_BYTE, '1, '1, 16'hFFFF, 16'hFFFF, 8'h30 + 8'(k), 0, ST_NONE, 32'd0, 16'd0);
    end
    add_row(FUNC_END,    32'd0, 32'd0, 16'd0, 16'd0, 8'h00, 1, ST_BLOB_OK, 32'hCBF4_3926, 16'd9);
    // end in the middle of a chunk: length mismatch
    add_row(FUNC_BEGIN,  32'd5, 32'd0, 16'd0, 16'd0, 8'h00, 1, ST_NONE, 32'd0, 16'd0);
    add_row(FUNC_BYTE,   32'd0, 32'd0, 16'd0, 16'd5, 8'h00, 0, ST_NONE, 32'd0, 16'd0);
    add_row(FUNC_END,    32'd0, 32'd0, 16'd0, 16'd0, 8'h00, 0, ST_NONE, 32'd0, 16'd0);
  endtask

  // One random blob. Half are clean, the rest carry one defect or are noise.
  task automatic run_random_blob();
    in_item_t    plan[$];
    in_item_t    it;
    logic [7:0]  data[$];
    int          starts[$];
    int          n, pos, clen, seq, pick, k, room;
    logic [31:0] crc;
    pick = $urandom_range(0, 99);
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 200) : $urandom_range(0, 16);
    crc  = CRC_ALL_ONES;
    for (k = 0; k < n; k++) begin
      data.push_back(8'($urandom));
      crc = crc32_step(crc, data[k]);
    end
    it              = random_req(FUNC_BEGIN);
    it.declared_len = n;
    it.expected_crc = crc ^ CRC_ALL_ONES;
    plan.push_back(it);
    pos = 0;
    seq = 0;
    if (n == 0 && $urandom_range(0, 1) == 1) begin
      starts.push_back(plan.size());
      it             = random_req(FUNC_BYTE);
      it.chunk_index = 16'(seq);
      it.chunk_len   = 16'd0;
      plan.push_back(it);
      seq++;
    end
    while (pos < n) begin
      room = (n - pos > 12) ? 12 : n - pos;
      clen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, room);
      starts.push_back(plan.size());
      if (clen == 0) begin
        it             = random_req(FUNC_BYTE);
        it.chunk_index = 16'(seq);
        it.chunk_len   = 16'd0;
        plan.push_back(it);
      end else begin
        for (k = 0; k < clen; k++) begin
          it = random_req(FUNC_BYTE);
          if (k == 0) begin
            it.chunk_index = 16'(seq);
            it.chunk_len   = 16'(clen);
          end
          it.data_byte = data[pos + k];
          plan.push_back(it);
        end
      end
      pos += clen;
      seq++;
    end
    plan.push_back(random_req(FUNC_END));

    if (pick < 50) begin
      // clean blob
    end else if (pick < 58) begin
      plan[0].expected_crc = plan[0].expected_crc ^ (32'd1 << $urandom_range(0, 31));
    end else if (pick < 64) begin
      plan[0].declared_len = n + $urandom_range(1, 8);           // end comes short
    end else if (pick < 70) begin
      if (n > 0) plan[0].declared_len = $urandom_range(0, n - 1); // some chunk overflows
    end else if (pick < 75) begin
      if (starts.size() > 0) begin
        k = starts[$urandom_range(0, starts.size() - 1)];
        plan[k].chunk_index = plan[k].chunk_index ^ 16'($urandom_range(1, 65535));
      end
    end else if (pick < 80) begin
      if (starts.size() > 0) begin
        k = starts[$urandom_range(0, starts.size() - 1)];
        plan[k].chunk_len = 16'($urandom);
      end
    end else if (pick < 87) begin
      // cut short, possibly inside a chunk
      k = $urandom_range(1, plan.size() - 1);
      while (plan.size() > k) void'(plan.pop_back());
      plan.push_back(random_req(FUNC_END));
    end else if (pick < 91) begin
      void'(plan.pop_back());                                 // next begin restarts
    end else if (pick < 96) begin
      plan[0].declared_len = $urandom_range(BUF_CAP + 1, 32'hFFFF_FFFF);
    end else begin
      plan.delete();
      repeat (6) plan.push_back(random_req(func_e'(2'($urandom_range(0, 3)))));
    end

    foreach (plan[i]) send_req(plan[i], 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Request side: reset, directed table, random blobs, drain
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni             <= 1'b0;
    hold_off           <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= '0;
    in_ch.declared_len <= '0;
    in_ch.expected_crc <= '0;
    in_ch.chunk_index  <= '0;
    in_ch.chunk_len    <= '0;
    in_ch.data_byte    <= '0;
    sender_calm     = 1'b0;
    mismatch_count  = 0;
    work_count      = 0;
    blob_open       = 1'b0;
    blob_oversize   = 1'b0;
    decl_len        = '0;
    rx_count        = '0;
    want_crc        = '0;
    chunk_seq       = '0;
    chunk_remaining = '0;
    crc_acc         = CRC_ALL_ONES;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    build_directed();
    foreach (directed_rows[i]) begin
      send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    work_count = 0;
    while (work_count < RANDOM_REQS) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      run_random_blob();
    end

    sender_calm = 1'b0;

    in_ch.valid <= 1'b0;
    while (predicted_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** chunked_blob_receiver_crc32_core: PASSED **");
    end else begin
      $display("** chunked_blob_receiver_crc32_core: FAILED **");
    end
    $finish;
  end

  // One long hold-off on the result side while requests keep coming, so both
  // pipeline registers fill and the input ready drops.
  initial begin : backpressure
    wait (work_count >= HOLD_AFTER);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Result side: random ready, compare against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string why, input out_item_t want, input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t %s", $realtime, why);
      $display("  exp: en=%0d addr=%h byte=%h st=%0d crc=%h len=%0d", want.store_enable,
               want.store_address, want.store_byte, want.status, want.computed_crc,
               want.blob_length);
      $display("  got: en=%0d addr=%h byte=%h st=%0d crc=%h len=%0d", got.store_enable,
               got.store_address, got.store_byte, got.status, got.computed_crc,
               got.blob_length);
    end
  endtask

  initial begin : result_side
    out_item_t got;
    out_item_t want;
    int        stall_left;
    int        calm_left;
    stall_left = 0;
    calm_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.store_enable  = out_ch.store_enable;
        got.store_address = out_ch.store_address;
        got.store_byte    = out_ch.store_byte;
        got.status        = status_e'(out_ch.status);
        got.computed_crc  = out_ch.computed_crc;
        got.blob_length   = out_ch.blob_length;
        if (predicted_outcomes.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, got);
        end else begin
          want = predicted_outcomes.pop_front();
          if (got.store_enable  !== want.store_enable  ||
              got.store_address !== want.store_address ||
              got.store_byte    !== want.store_byte    ||
              got.status        !== want.status        ||
              got.computed_crc  !== want.computed_crc  ||
              got.blob_length   !== want.blob_length) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
      // next-cycle ready: forced hold-off, calm stretch, random stall or open
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(30, 200);
        else if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no handshake on either side means a hang
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("** chunked_blob_receiver_crc32_core: FAILED **");
    $finish;
  end

endmodule
